>>> hw/rtl/spi_register_access_master_top_defines.svh
// assertion macros used by the spi register access master rtl
`ifndef SPI_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH
`define SPI_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, clocked on clk_i, off during reset
`define SRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, clocked on clk_i, off during reset
`define SRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRM_ASSERT_IMP(lbl, ante, cons, msg)
`define SRM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/srm_pkg.sv
// types and constants of the spi register access master
`timescale 1ns / 1ps
`default_nettype none
package srm_pkg;

  localparam int unsigned DivW  = 16;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned AddrW = 6;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitW  = 3;

  localparam logic [BitW-1:0] LastBit = BitW'(ByteW - 1);

  // serial clock phase of one bit, one-hot
  typedef enum logic [2:0] {
    PH_MOSI = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_e;

  // one classified tick, as it sits in the queue
  typedef struct packed {
    logic             req;
    logic             wr;
    logic [ByteW-1:0] first_byte;
    logic [ByteW-1:0] second_byte;
    logic             miso;
  } tick_t;

endpackage
`default_nettype wire

>>> hw/rtl/srm_if.sv
// handshake channels of the spi register access master
`timescale 1ns / 1ps
`default_nettype none
interface srm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_valid;
  logic                        action;
  logic [srm_pkg::AddrW-1:0]   address;
  logic [srm_pkg::ByteW-1:0]   write_data;
  logic                        miso;

  modport source (output valid, req_valid, action, address, write_data, miso,
                  input ready);
  modport sink   (input valid, req_valid, action, address, write_data, miso,
                  output ready);
endinterface

interface srm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        cs_n;
  logic                        sck;
  logic                        mosi;
  logic [srm_pkg::ByteW-1:0]   read_data;
  logic                        done_res;
  logic                        busy_res;

  modport source (output valid, cs_n, sck, mosi, read_data, done_res, busy_res,
                  input ready);
  modport sink   (input valid, cs_n, sck, mosi, read_data, done_res, busy_res,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/srm_front.sv
// front end: accepts tick beats, builds the frame bytes, two-entry queue
`timescale 1ns / 1ps
`default_nettype none
module srm_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  srm_in_if.sink              in_i,
  output srm_pkg::tick_t      q_entry_o,
  output logic                q_valid_o,
  input  wire logic           q_pop_i
);

  srm_pkg::tick_t entry_d;
  srm_pkg::tick_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push;

  // address byte: read flag on top, address shifted left by one
  always_comb begin
    entry_d.req         = in_i.req_valid;
    entry_d.wr          = in_i.action;
    entry_d.first_byte  = {~in_i.action, in_i.address, 1'b0};
    entry_d.second_byte = in_i.action ? in_i.write_data : '0;
    entry_d.miso        = in_i.miso;
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/srm_back.sv
// back end: spi transfer engine, half period register and result register
`timescale 1ns / 1ps
`default_nettype none
`include "spi_register_access_master_top_defines.svh"
module srm_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [srm_pkg::CfgW-1:0]  cfg_wdata_i,
  input  wire srm_pkg::tick_t            q_entry_i,
  input  wire logic                      q_valid_i,
  output logic                           q_pop_o,
  srm_out_if.source                      out_o
);

  logic [srm_pkg::DivW-1:0]  half_q, half_eff, tick_q, tick_d, tick_inc;
  logic                      active_q, active_d, wr_q, wr_d, byte_q, byte_d;
  logic [srm_pkg::BitW-1:0]  bit_q, bit_d;
  srm_pkg::phase_e           phase_q, phase_d;
  logic [srm_pkg::ByteW-1:0] so_q, so_d, si_q, si_d, sec_q, sec_d, rd_q, rd_d;
  logic                      cs_q, cs_d, sck_q, sck_d, mosi_q, mosi_d, done_d;
  logic                      out_valid_q, out_done_q;
  logic                      step_end;

  assign half_eff = (half_q == '0) ? srm_pkg::DivW'(1) : half_q;
  assign tick_inc = tick_q + srm_pkg::DivW'(1);
  assign step_end = (tick_inc >= half_eff) || (tick_inc == '0);
  assign q_pop_o  = q_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    active_d = active_q;
    wr_d     = wr_q;
    byte_d   = byte_q;
    bit_d    = bit_q;
    phase_d  = phase_q;
    tick_d   = tick_q;
    so_d     = so_q;
    si_d     = si_q;
    sec_d    = sec_q;
    rd_d     = rd_q;
    cs_d     = cs_q;
    sck_d    = sck_q;
    mosi_d   = mosi_q;
    done_d   = 1'b0;
    if (!active_q) begin
      if (q_entry_i.req) begin
        active_d = 1'b1;
        wr_d     = q_entry_i.wr;
        byte_d   = 1'b0;
        bit_d    = '0;
        phase_d  = srm_pkg::PH_MOSI;
        tick_d   = '0;
        so_d     = q_entry_i.first_byte;
        sec_d    = q_entry_i.second_byte;
        si_d     = '0;
        cs_d     = 1'b0;
        sck_d    = 1'b0;
        mosi_d   = q_entry_i.first_byte[srm_pkg::ByteW-1];
      end
    end else if (!step_end) begin
      tick_d = tick_inc;
    end else begin
      tick_d = '0;
      case (phase_q)
        srm_pkg::PH_HIGH: begin
          si_d    = {si_q[srm_pkg::ByteW-2:0], q_entry_i.miso};
          sck_d   = 1'b0;
          phase_d = srm_pkg::PH_LOW;
        end
        srm_pkg::PH_LOW: begin
          so_d    = {so_q[srm_pkg::ByteW-2:0], 1'b0};
          phase_d = srm_pkg::PH_MOSI;
          if (bit_q == srm_pkg::LastBit) begin
            bit_d = '0;
            if (!byte_q) begin
              byte_d = 1'b1;
              so_d   = sec_q;
              si_d   = '0;
              mosi_d = sec_q[srm_pkg::ByteW-1];
            end else begin
              cs_d     = 1'b1;
              if (!wr_q) rd_d = si_q;
              active_d = 1'b0;
              byte_d   = 1'b0;
              done_d   = 1'b1;
            end
          end else begin
            bit_d  = bit_q + srm_pkg::BitW'(1);
            mosi_d = so_q[srm_pkg::ByteW-2];
          end
        end
        default: begin
          // mosi half period, also any stray phase code
          sck_d   = 1'b1;
          phase_d = srm_pkg::PH_HIGH;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= srm_pkg::DivW'(1);
      active_q    <= 1'b0;
      wr_q        <= 1'b0;
      byte_q      <= 1'b0;
      bit_q       <= '0;
      phase_q     <= srm_pkg::PH_MOSI;
      tick_q      <= '0;
      so_q        <= '0;
      si_q        <= '0;
      sec_q       <= '0;
      rd_q        <= '0;
      cs_q        <= 1'b1;
      sck_q       <= 1'b0;
      mosi_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) half_q <= cfg_wdata_i[srm_pkg::DivW-1:0];
      if (q_pop_o) begin
        active_q   <= active_d;
        wr_q       <= wr_d;
        byte_q     <= byte_d;
        bit_q      <= bit_d;
        phase_q    <= phase_d;
        tick_q     <= tick_d;
        so_q       <= so_d;
        si_q       <= si_d;
        sec_q      <= sec_d;
        rd_q       <= rd_d;
        cs_q       <= cs_d;
        sck_q      <= sck_d;
        mosi_q     <= mosi_d;
        out_done_q <= done_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pins and status come straight from the engine state of the last step
  assign out_o.valid     = out_valid_q;
  assign out_o.cs_n      = cs_q;
  assign out_o.sck       = sck_q;
  assign out_o.mosi      = mosi_q;
  assign out_o.read_data = rd_q;
  assign out_o.done_res  = out_done_q;
  assign out_o.busy_res  = active_q;

  `SRM_ASSERT_IMP(a_idle_pins, !active_q, cs_q && !sck_q, "idle bus not parked")
  `SRM_ASSERT_IMP(a_sck_phase, sck_q, active_q && (phase_q == srm_pkg::PH_HIGH),
                  "sck high outside high phase")
  `SRM_ASSERT_NXT(a_start, q_pop_o && !active_q && q_entry_i.req,
                  active_q && !cs_q && out_valid_q, "request did not start a frame")
  `SRM_ASSERT_IMP(a_done_idle, out_done_q, !active_q && cs_q, "done while still busy")

endmodule
`default_nettype wire

>>> hw/rtl/spi_register_access_master_top.sv
// top level of the spi register access master
// data path: the accepting edge writes the queue and the pop of that entry runs the engine
// into the result register, so the result beat is valid right after that pop; throughput:
// one tick beat per cycle while the sink is ready, set by the single-step engine update
// reset: asynchronous active low; pins idle (cs high, sck and mosi low), queue empty,
// half period register back to one, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module spi_register_access_master_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [srm_pkg::CfgW-1:0]  cfg_wdata_i,
  srm_in_if.sink                         in_i,
  srm_out_if.source                      out_o
);

  // queue head between the front end and the engine
  srm_pkg::tick_t q_entry;
  logic           q_valid;
  logic           q_pop;

  // front end: takes a beat whenever the queue has room, precomputes the
  // address and data bytes so the engine only shifts
  srm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_entry_o (q_entry),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  // engine: one tick per pop, pops only when the result register can load,
  // so a stalled sink backs up into the queue and then into the input
  srm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_entry_i   (q_entry),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

>>> sim/testbench.sv
// testbench for the spi register access master: tick beats in, pin level beats checked
`timescale 1ns / 1ps
module testbench;

  // one tick beat as driven on the input channel
  typedef struct packed {
    logic                      req;
    logic                      wr;
    logic [srm_pkg::AddrW-1:0] addr;
    logic [srm_pkg::ByteW-1:0] wdata;
    logic                      miso;
  } tick_t;

  // pin levels and status after one tick
  typedef struct packed {
    logic                      cs_n;
    logic                      sck;
    logic                      mosi;
    logic [srm_pkg::ByteW-1:0] read_data;
    logic                      done;
    logic                      busy;
  } pins_t;

  // tracks the spi engine tick by tick and holds the pin levels still due
  class spi_pin_tracker;
    logic [srm_pkg::CfgW-1:0]  half_ticks;
    logic                      active;
    logic                      wr_xfer;
    logic                      byte_hi;
    logic [srm_pkg::BitW-1:0]  bit_no;
    srm_pkg::phase_e           ph;
    logic [srm_pkg::DivW-1:0]  ticks;
    logic [srm_pkg::ByteW-1:0] out_sr;
    logic [srm_pkg::ByteW-1:0] in_sr;
    logic [srm_pkg::ByteW-1:0] data_byte;
    logic [srm_pkg::ByteW-1:0] last_rd;
    logic                      cs_n;
    logic                      sck;
    logic                      mosi;
    pins_t                     pins_due[$];
    int                        fails;

    function new();
      half_ticks = 1;
      active     = 1'b0;
      wr_xfer    = 1'b0;
      byte_hi    = 1'b0;
      bit_no     = '0;
      ph         = srm_pkg::PH_MOSI;
      ticks      = '0;
      out_sr     = '0;
      in_sr      = '0;
      data_byte  = '0;
      last_rd    = '0;
      cs_n       = 1'b1;
      sck        = 1'b0;
      mosi       = 1'b0;
      fails      = 0;
    endfunction

    // advance the engine by one accepted tick and queue the pin levels it gives
    function void note_tick(tick_t t);
      pins_t                    p;
      logic [srm_pkg::DivW-1:0] h;
      p.done = 1'b0;
      if (!active) begin
        if (t.req) begin
          active    = 1'b1;
          wr_xfer   = t.wr;
          byte_hi   = 1'b0;
          bit_no    = '0;
          ph        = srm_pkg::PH_MOSI;
          ticks     = '0;
          out_sr    = {~t.wr, t.addr, 1'b0};
          data_byte = t.wr ? t.wdata : '0;
          in_sr     = '0;
          cs_n      = 1'b0;
          sck       = 1'b0;
          mosi      = out_sr[srm_pkg::ByteW-1];
        end
      end else begin
        h     = (half_ticks == 0) ? 1 : half_ticks;
        ticks = ticks + 1'b1;
        if (ticks >= h || ticks == 0) begin
          ticks = '0;
          case (ph)
            srm_pkg::PH_HIGH: begin
              in_sr = {in_sr[srm_pkg::ByteW-2:0], t.miso};
              sck   = 1'b0;
              ph    = srm_pkg::PH_LOW;
            end
            srm_pkg::PH_LOW: begin
              out_sr = out_sr << 1;
              ph     = srm_pkg::PH_MOSI;
              if (bit_no == srm_pkg::LastBit) begin
                bit_no = '0;
                if (!byte_hi) begin
                  byte_hi = 1'b1;
                  out_sr  = data_byte;
                  in_sr   = '0;
                  mosi    = out_sr[srm_pkg::ByteW-1];
                end else begin
                  cs_n    = 1'b1;
                  if (!wr_xfer) last_rd = in_sr;
                  active  = 1'b0;
                  byte_hi = 1'b0;
                  p.done  = 1'b1;
                end
              end else begin
                bit_no = bit_no + 1'b1;
                mosi   = out_sr[srm_pkg::ByteW-1];
              end
            end
            default: begin
              sck = 1'b1;
              ph  = srm_pkg::PH_HIGH;
            end
          endcase
        end
      end
      p.cs_n      = cs_n;
      p.sck       = sck;
      p.mosi      = mosi;
      p.read_data = last_rd;
      p.busy      = active;
      pins_due.push_back(p);
    endfunction

    function void cmp(string field, logic [srm_pkg::ByteW-1:0] want,
                      logic [srm_pkg::ByteW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        fails++;
      end
    endfunction

    function void check_pins(pins_t got);
      pins_t want;
      if (pins_due.size() == 0) begin
        $display("%0t: result beat with nothing pending, expected none got %0h",
                 $time, got);
        fails++;
        return;
      end
      want = pins_due.pop_front();
      cmp("cs_n", want.cs_n, got.cs_n);
      cmp("sck", want.sck, got.sck);
      cmp("mosi", want.mosi, got.mosi);
      cmp("read_data", want.read_data, got.read_data);
      cmp("done_res", want.done, got.done);
      cmp("busy_res", want.busy, got.busy);
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [srm_pkg::CfgW-1:0] cfg_wdata;
  // no idling on either side while set
  bit                       steady;

  spi_pin_tracker  tracker;

  srm_in_if  in_if ();
  srm_out_if out_if ();

  spi_register_access_master_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  // watch both channels; values read at the edge are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        tracker.note_tick({in_if.req_valid, in_if.action, in_if.address,
                           in_if.write_data, in_if.miso});
      end
      if (out_if.valid && out_if.ready) begin
        tracker.check_pins({out_if.cs_n, out_if.sck, out_if.mosi, out_if.read_data,
                            out_if.done_res, out_if.busy_res});
      end
    end
  end

  // result side: random stall before taking each beat
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // build one tick beat
  function automatic tick_t mk(bit req, bit wr, int addr, int wdata, bit miso);
    tick_t t;
    t.req   = req;
    t.wr    = wr;
    t.addr  = addr[srm_pkg::AddrW-1:0];
    t.wdata = wdata[srm_pkg::ByteW-1:0];
    t.miso  = miso;
    return t;
  endfunction

  // random tick, mostly carrying a request so the engine restarts soon after done;
  // address and data lean toward their extremes now and then
  function automatic tick_t rand_tick();
    int pick_a;
    int pick_d;
    pick_a = $urandom_range(0, 5);
    pick_d = $urandom_range(0, 5);
    return mk($urandom_range(0, 3) != 0, $urandom_range(0, 1),
              (pick_a == 0) ? 0 : (pick_a == 1) ? 63 : $urandom_range(0, 63),
              (pick_d == 0) ? 0 : (pick_d == 1) ? 255 : $urandom_range(0, 255),
              $urandom_range(0, 1));
  endfunction

  // drive one tick beat after a random gap, return on the accepting edge
  task automatic send_tick(input tick_t t);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.req_valid  <= t.req;
    in_if.action     <= t.wr;
    in_if.address    <= t.addr;
    in_if.write_data <= t.wdata;
    in_if.miso       <= t.miso;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic run_ticks(input int n);
    for (int i = 0; i < n; i++) send_tick(rand_tick());
  endtask

  // stop sending and wait for every pending pin beat; the first edge lets the
  // monitor note a beat accepted at the edge we returned on
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pins_due.size() != 0) @(posedge clk_i);
  endtask

  // new half period, only with nothing in flight; a transfer may still be open
  task automatic write_half(input logic [srm_pkg::CfgW-1:0] ticks);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tracker.half_ticks = ticks;
  endtask

  initial begin
    tracker = new();
    steady  = 1'b0;
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.req_valid  <= 1'b0;
    in_if.action     <= 1'b0;
    in_if.address    <= '0;
    in_if.write_data <= '0;
    in_if.miso       <= 1'b0;
    out_if.ready     <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset half period, request fields without req_valid,
    // write at top address and data, read request while busy, miso toggling
    send_tick(mk(0, 1, 63, 255, 1));
    send_tick(mk(1, 1, 63, 255, 0));
    send_tick(mk(1, 0, 0, 0, 1));
    for (int i = 0; i < 22; i++) begin
      send_tick(mk(i % 4 == 0, i % 2, i * 3, i * 37, (i / 2) % 2));
    end

    // zero half period counts as one
    write_half('0);
    run_ticks(100);

    // largest half period stalls the open transfer, no idling here
    steady = 1'b1;
    write_half('1);
    run_ticks(15);

    // shrinking mid transfer: count already past the new value
    steady = 1'b0;
    write_half(2);
    run_ticks(110);

    steady = 1'b1;
    write_half(1);
    run_ticks(50);
    steady = 1'b0;
    run_ticks(50);

    write_half($urandom_range(1, 3));
    run_ticks(60);

    // all beats back, then a few edges for anything stray
    drain();
    repeat (4) @(posedge clk_i);
    if (tracker.fails == 0 && tracker.pins_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
